// ----- sv/dss_pkg.sv -----
// Shared constants and a helper function for the dive sample summarizer.
// No dependencies.
package dss_pkg;
  localparam int unsigned TANKS_DEF = 8;
  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_TANK    = 2'd2;
  localparam logic [1:0] REG_MAX_DEPTH = 2'd0;
  localparam logic [1:0] REG_MEAN_DEPTH = 2'd1;
  localparam logic [1:0] REG_WATER_TEMP = 2'd2;
  localparam logic [1:0] REG_DURATION = 2'd3;
  localparam int unsigned NEAR_LIMIT = 1000;
  localparam int unsigned LIN_TOL = 150;
  localparam logic [21:0] STEP_UNSET = 22'h200000;
  localparam logic [21:0] STEP_BROKEN = 22'h3FFFFF;
  localparam logic [63:0] SUM_POS = 64'sh4000000000000000;
  localparam logic [63:0] SUM_NEG = 64'shC000000000000000;

  // True when val is nonzero and more than NEAR_LIMIT away from old.
  function automatic logic far_from(input logic [19:0] old, input logic [19:0] val);
    logic [20:0] d;
    begin
      d = (old > val) ? {1'b0, old} - {1'b0, val} : {1'b0, val} - {1'b0, old};
      far_from = (val != 20'd0) && (d > 21'(NEAR_LIMIT));
    end
  endfunction
endpackage

// ----- sv/dss_div.sv -----
// Restoring divider: 64-bit signed dividend by 26-bit positive divisor.
// One quotient bit per cycle; does not use dss_pkg.
module dss_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [25:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [63:0] q;
  logic [26:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic        neg;
  logic [26:0] trial;

  assign trial = {rem[25:0], q[63]} - {1'b0, divisor};

  // Shift one dividend bit in per cycle, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= dividend[63];
        q    <= dividend[63] ? (64'd0 - dividend) : dividend;
        rem  <= '0;
        cnt  <= 7'd0;
      end else if (busy) begin
        if (!trial[26]) begin
          rem <= trial;
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[25:0], q[63]};
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? (64'd0 - q) : q;
endmodule

// ----- sv/dive_sample_summarizer_top.sv -----
// Dive sample summarizer top level.
// Uses dss_pkg and dss_div.
//
// Input stream s_axis: one depth-log sample per request. Output stream m_axis
// gives a cleaned sample per input; a sample with tlast also yields a summary
// (tuser=1) and one tank report per tank (tuser=2), the final one with tlast.
// Register port (APB): reported max depth, mean depth, water temp, duration
// at byte addresses 0, 4, 8, 12. pready is always high.
// Flow: an ordinary sample steps through accept, multiply, load the result
// register, and the result taken by the receiver; output stalls add to that,
// and the next sample is taken once the result is taken. A last sample
// further runs the serial divider for the mean depth, then gives the summary
// and walks the tanks, one report per accepted cycle.
// The integral term uses a 24x21 multiply registered before accumulation.
// Reset clears all tracking state and registers; tank arrays clear at once.
// A stalled receiver holds the result register and s_axis_tready stays low.
module dive_sample_summarizer_top #(
  parameter int unsigned TANKS = dss_pkg::TANKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // time_s[23:0], depth_mm[43:24], temp_mk[63:44], pressure_mbar[83:64],
  // tank_index[86:84], pad
  input  logic [87:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pressure_out[19:0], temp_out[39:20], duration_out[63:40],
  // mean_depth_out[83:64], max_depth_out[103:84], water_temp_out[123:104],
  // tank_number[126:124], tank_first_pressure[146:127],
  // tank_last_pressure[166:147], tank_linear[167]
  output logic [167:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dss_pkg::*;

  localparam int TW = (TANKS > 1) ? $clog2(TANKS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_OUT, S_DSTART, S_DIV, S_SUM, S_TANK} state_t;
  state_t state;

  // registers
  logic [19:0] r_maxd, r_mean, r_wt;
  logic [23:0] r_dur;
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_maxd <= '0; r_mean <= '0; r_wt <= '0; r_dur <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MAX_DEPTH:  r_maxd <= pwdata[19:0];
        REG_MEAN_DEPTH: r_mean <= pwdata[19:0];
        REG_WATER_TEMP: r_wt <= pwdata[19:0];
        REG_DURATION:   r_dur <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_DEPTH:  prdata = {12'd0, r_maxd};
      REG_MEAN_DEPTH: prdata = {12'd0, r_mean};
      REG_WATER_TEMP: prdata = {12'd0, r_wt};
      REG_DURATION:   prdata = {8'd0, r_dur};
      default:        prdata = '0;
    endcase
  end

  // input fields
  logic [23:0] in_t;
  logic [19:0] in_d, in_tp, in_p;
  logic [2:0]  in_k;
  logic [TW-1:0] kidx;
  assign in_t  = s_axis_tdata[23:0];
  assign in_d  = s_axis_tdata[43:24];
  assign in_tp = s_axis_tdata[63:44];
  assign in_p  = s_axis_tdata[83:64];
  assign in_k  = s_axis_tdata[86:84];
  assign kidx  = TW'(in_k);

  // tracking state
  logic [23:0] prev_time;
  logic [19:0] prev_depth, prev_temp, prev_pressure, deepest, coldest;
  logic [3:0]  prev_tank;
  logic [24:0] start_time, end_time;
  logic [63:0] depth_time_sum;
  logic [21:0] tank_step  [TANKS];
  logic [19:0] tank_first [TANKS];
  logic [19:0] tank_last  [TANKS];

  // product stage
  logic [24:0] dt;
  logic [20:0] dsum;
  logic [45:0] prod;
  logic        is_last;
  logic [TW-1:0] walk;

  // divider
  logic        div_start, div_done;
  logic [63:0] div_q;
  logic [25:0] span_reg;
  logic [25:0] span_c;
  logic [24:0] st_eff;

  assign st_eff = start_time[24] ? 25'd0 : start_time;
  assign span_c = {1'b0, end_time} - {1'b0, st_eff};
  assign div_start = (state == S_DSTART);

  // Fold the span sign into the dividend so the quotient sign follows both
  dss_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(span_reg[25] ? (64'd0 - depth_time_sum) : depth_time_sum),
    .divisor(span_reg[25] ? (26'd0 - span_reg) : span_reg),
    .done(div_done), .quotient(div_q)
  );

  // per-sample combinational updates
  logic [19:0] pout, tout, cur, sd;
  logic        kin;
  logic [21:0] stepk;
  assign kin = {2'b0, in_k} < 5'(TANKS);
  assign stepk = kin ? tank_step[kidx] : STEP_UNSET;
  assign pout = ({1'b0, in_k} == prev_tank && in_p == prev_pressure) ? 20'd0 : in_p;
  assign tout = (in_tp != 20'd0 && in_tp == prev_temp) ? 20'd0 : in_tp;
  assign cur  = (in_p > prev_pressure) ? in_p - prev_pressure : prev_pressure - in_p;
  assign sd   = (cur > stepk[19:0]) ? cur - stepk[19:0] : stepk[19:0] - cur;

  // integral term: signed dt times depth sum, halved toward zero
  logic signed [46:0] prod_s;
  logic signed [63:0] term, sum_next;
  assign prod_s = dt[24] ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
  assign term = 64'(prod_s >>> 1) + ((prod_s[46] && prod_s[0]) ? 64'sd1 : 64'sd0);
  always_comb begin
    if (term > 0 && $signed(depth_time_sum) > $signed(SUM_POS) - term)
      sum_next = SUM_POS;
    else if (term < 0 && $signed(depth_time_sum) < $signed(SUM_NEG) - term)
      sum_next = SUM_NEG;
    else
      sum_next = $signed(depth_time_sum) + term;
  end

  // summary values
  logic signed [63:0] mraw;
  logic [19:0] mean_c, sum_dur_mean, sum_maxd, sum_wt;
  logic [23:0] sum_dur;
  logic        has_end;
  assign has_end = !end_time[24];
  assign mraw = (span_reg == 26'd0) ? depth_time_sum : div_q;
  assign mean_c = mraw[63] ? 20'd0 : ((mraw > 64'sd1048575) ? 20'hFFFFF : mraw[19:0]);
  assign sum_dur = (has_end && !span_reg[25] && span_reg != 0) ? span_reg[23:0] : r_dur;
  assign sum_dur_mean = (has_end && far_from(r_mean, mean_c)) ? mean_c : r_mean;
  assign sum_maxd = (has_end && far_from(r_maxd, deepest)) ? deepest : r_maxd;
  assign sum_wt = (has_end && far_from(r_wt, coldest)) ? coldest : r_wt;

  logic [TW-1:0] last_tank;
  assign last_tank = TW'(TANKS - 1);
  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      prev_time <= '0; prev_depth <= '0; prev_temp <= '0; prev_pressure <= '0;
      prev_tank <= 4'd15; start_time <= 25'h1000000; end_time <= 25'h1000000;
      deepest <= '0; coldest <= '0; depth_time_sum <= '0;
      for (int i = 0; i < TANKS; i++) begin
        tank_step[i] <= STEP_UNSET; tank_first[i] <= '0; tank_last[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          // linearity tracking and dedup
          if ({1'b0, in_k} == prev_tank && kin && stepk != STEP_BROKEN
              && prev_pressure != 0) begin
            if (stepk == STEP_UNSET) tank_step[kidx] <= {2'b0, cur};
            else if (cur != 0 && (stepk[21:20] != 2'b0 || sd > 20'(LIN_TOL)))
              tank_step[kidx] <= STEP_BROKEN;
          end
          prev_tank <= {1'b0, in_k};
          prev_pressure <= in_p;
          if (prev_depth != 0) end_time <= {1'b0, in_t};
          if (in_d != 0) begin
            if (start_time[24]) start_time <= {1'b0, prev_time};
            if (in_d > deepest) deepest <= in_d;
          end
          if (pout != 0 && kin) begin
            if (tank_first[kidx] == 0) tank_first[kidx] <= pout;
            tank_last[kidx] <= pout;
          end
          if (in_tp != 0) begin
            prev_temp <= in_tp;
            if (coldest == 0 || in_tp < coldest) coldest <= in_tp;
          end
          dt <= {1'b0, in_t} - {1'b0, prev_time};
          dsum <= {1'b0, prev_depth} + {1'b0, in_d};
          prev_depth <= in_d;
          prev_time <= in_t;
          is_last <= s_axis_tlast;
          m_axis_tuser <= KIND_SAMPLE;
          m_axis_tlast <= !s_axis_tlast;
          m_axis_tdata <= {128'd0, tout, pout};
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= {21'd0, dt[24] ? 25'd0 - dt : dt} * {25'd0, dsum};
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            depth_time_sum <= sum_next;
            m_axis_tvalid <= 1'b1;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            span_reg <= span_c;
            if (is_last) state <= S_DSTART;
            else state <= S_IDLE;
          end
        end
        // Launch the divider for one cycle
        S_DSTART: state <= S_DIV;
        S_DIV: if (div_done) begin
          m_axis_tuser <= KIND_SUMMARY;
          m_axis_tlast <= 1'b0;
          m_axis_tdata <= {44'd0, sum_wt, sum_maxd, sum_dur_mean, sum_dur, 40'd0};
          m_axis_tvalid <= 1'b1;
          walk <= '0;
          state <= S_SUM;
        end
        S_SUM, S_TANK: if (m_axis_tready) begin
          if (state == S_TANK && walk == last_tank) begin
            m_axis_tvalid <= 1'b0;
            prev_time <= '0; prev_depth <= '0; prev_temp <= '0; prev_pressure <= '0;
            prev_tank <= 4'd15; start_time <= 25'h1000000; end_time <= 25'h1000000;
            deepest <= '0; coldest <= '0; depth_time_sum <= '0;
            for (int i = 0; i < TANKS; i++) begin
              tank_step[i] <= STEP_UNSET; tank_first[i] <= '0; tank_last[i] <= '0;
            end
            state <= S_IDLE;
          end else begin
            if (state == S_TANK) walk <= walk + TW'(1);
            m_axis_tuser <= KIND_TANK;
            m_axis_tlast <= (state == S_TANK ? walk + TW'(1) : walk) == last_tank;
            m_axis_tdata <= {
              tank_step[state == S_TANK ? walk + TW'(1) : walk] != STEP_UNSET &&
              tank_step[state == S_TANK ? walk + TW'(1) : walk] != STEP_BROKEN,
              tank_last[state == S_TANK ? walk + TW'(1) : walk],
              tank_first[state == S_TANK ? walk + TW'(1) : walk],
              3'((state == S_TANK) ? walk + TW'(1) : walk), 124'd0};
            state <= S_TANK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !m_axis_tvalid) else $error("divider started with result pending");
  a_tank_kind: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && state == S_TANK) |-> m_axis_tuser == KIND_TANK)
    else $error("tank walk with wrong kind");
`endif
endmodule
